/* sv/vpa_pkg.sv */
// Shared types, constants and the arctangent table for the vector pair angle core.
`default_nettype none

package vpa_pkg;

   localparam int COORD_BITS    = 16;
   localparam int FRAC_BITS     = 8;
   localparam int CORDIC_STAGES = 16;

   localparam int ZBITS      = 24;
   localparam int PRESHIFT   = 46 - COORD_BITS;
   localparam int ANGLE_BITS = 9 + FRAC_BITS;
   localparam int CW         = 48;
   localparam int ZW         = ZBITS + 9;
   localparam int FW         = ZBITS + 10;
   localparam int RSHIFT     = ZBITS - FRAC_BITS;
   localparam int RW         = FW - RSHIFT;

   localparam logic signed [ZW-1:0] QUARTER_Z  = ZW'(64'd90 << ZBITS);
   localparam logic [FW-1:0]        HALF_F     = FW'(64'd180 << ZBITS);
   localparam logic [FW-1:0]        FULL_F     = FW'(64'd360 << ZBITS);
   localparam logic [FW-1:0]        ROUND_HALF = FW'(64'd1 << (RSHIFT - 1));
   localparam logic [RW-1:0]        FULL_A     = RW'(64'd360 << FRAC_BITS);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] first_x;
      logic signed [COORD_BITS-1:0] first_y;
      logic signed [COORD_BITS-1:0] second_x;
      logic signed [COORD_BITS-1:0] second_y;
   } vpa_req_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] first_angle;
      logic [ANGLE_BITS-1:0] second_angle;
      logic [ANGLE_BITS-1:0] between_angle;
      logic                  undefined_flag;
      logic                  stop_flag;
   } vpa_rsp_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } vpa_lane_type;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic ax_zero;
      logic ay_zero;
   } vpa_flags_type;

   typedef struct packed {
      vpa_flags_type vec1;
      vpa_flags_type vec2;
   } vpa_meta_type;

   // atan(2^-i) in degrees * 2^24
   function automatic logic signed [ZW-1:0] vpa_atan(input int unsigned idx);
      logic signed [ZW-1:0] a;
      case (idx)
         0:  a = ZW'(754974720);
         1:  a = ZW'(445687602);
         2:  a = ZW'(235489088);
         3:  a = ZW'(119537938);
         4:  a = ZW'(60000934);
         5:  a = ZW'(30029717);
         6:  a = ZW'(15018523);
         7:  a = ZW'(7509720);
         8:  a = ZW'(3754917);
         9:  a = ZW'(1877466);
         10: a = ZW'(938734);
         11: a = ZW'(469367);
         12: a = ZW'(234684);
         13: a = ZW'(117342);
         14: a = ZW'(58671);
         15: a = ZW'(29335);
         16: a = ZW'(14668);
         17: a = ZW'(7334);
         18: a = ZW'(3667);
         19: a = ZW'(1833);
         20: a = ZW'(917);
         21: a = ZW'(458);
         22: a = ZW'(229);
         23: a = ZW'(115);
         24: a = ZW'(57);
         25: a = ZW'(29);
         26: a = ZW'(14);
         27: a = ZW'(7);
         28: a = ZW'(4);
         29: a = ZW'(2);
         30: a = ZW'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

/* sv/vpa_prep.sv */
// Input stage: absolute values, sign and axis flags, CORDIC start vectors.
`default_nettype none

module vpa_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  vpa_pkg::vpa_req_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output vpa_pkg::vpa_lane_type out_lane1,
   output vpa_pkg::vpa_lane_type out_lane2,
   output vpa_pkg::vpa_meta_type out_meta
);
   import vpa_pkg::*;

   logic         valid_ff;
   vpa_lane_type lane1_ff, lane1_in;
   vpa_lane_type lane2_ff, lane2_in;
   vpa_meta_type meta_ff, meta_in;

   function automatic logic [COORD_BITS-1:0] abs_coord(input logic signed [COORD_BITS-1:0] v);
      logic [COORD_BITS-1:0] r;
      r = v[COORD_BITS-1] ? COORD_BITS'(-v) : COORD_BITS'(v);
      return r;
   endfunction

   function automatic vpa_lane_type start_lane(input logic signed [COORD_BITS-1:0] x,
                                               input logic signed [COORD_BITS-1:0] y);
      vpa_lane_type l;
      l.x = CW'(abs_coord(x)) << PRESHIFT;
      l.y = CW'(abs_coord(y)) << PRESHIFT;
      l.z = '0;
      return l;
   endfunction

   function automatic vpa_flags_type flags_of(input logic signed [COORD_BITS-1:0] x,
                                              input logic signed [COORD_BITS-1:0] y);
      vpa_flags_type f;
      f.neg_x   = x[COORD_BITS-1];
      f.neg_y   = y[COORD_BITS-1];
      f.ax_zero = (x == '0);
      f.ay_zero = (y == '0);
      return f;
   endfunction

   always_comb begin
      lane1_in     = start_lane(in_data.first_x, in_data.first_y);
      lane2_in     = start_lane(in_data.second_x, in_data.second_y);
      meta_in.vec1 = flags_of(in_data.first_x, in_data.first_y);
      meta_in.vec2 = flags_of(in_data.second_x, in_data.second_y);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_lane1 = lane1_ff;
   assign out_lane2 = lane2_ff;
   assign out_meta  = meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lane1_ff <= lane1_in;
         lane2_ff <= lane2_in;
         meta_ff  <= meta_in;
      end
   end

endmodule

`default_nettype wire

/* sv/vpa_cordic.sv */
// Unrolled CORDIC vectoring pipeline, one iteration per register stage, two lanes.
`default_nettype none

module vpa_cordic (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  vpa_pkg::vpa_lane_type in_lane1,
   input  vpa_pkg::vpa_lane_type in_lane2,
   input  vpa_pkg::vpa_meta_type in_meta,
   output logic                  out_valid,
   input  logic                  out_ready,
   output vpa_pkg::vpa_lane_type out_lane1,
   output vpa_pkg::vpa_lane_type out_lane2,
   output vpa_pkg::vpa_meta_type out_meta
);
   import vpa_pkg::*;

   logic                 valid_ff  [CORDIC_STAGES];
   vpa_lane_type         lane1_ff  [CORDIC_STAGES];
   vpa_lane_type         lane2_ff  [CORDIC_STAGES];
   vpa_meta_type         meta_ff   [CORDIC_STAGES];
   logic                 valid_src [CORDIC_STAGES];
   vpa_lane_type         lane1_src [CORDIC_STAGES];
   vpa_lane_type         lane2_src [CORDIC_STAGES];
   vpa_meta_type         meta_src  [CORDIC_STAGES];
   vpa_lane_type         lane1_in  [CORDIC_STAGES];
   vpa_lane_type         lane2_in  [CORDIC_STAGES];
   logic [CORDIC_STAGES:0] rdy;

   function automatic vpa_lane_type step(input vpa_lane_type a, input int unsigned k);
      vpa_lane_type         r;
      logic signed [CW-1:0] xa, ya, dx, dy;
      logic signed [ZW-1:0] za;
      xa = a.x;
      ya = a.y;
      za = a.z;
      dx = ya >>> k;
      dy = xa >>> k;
      if (!ya[CW-1]) begin
         r.x = xa + dx;
         r.y = ya - dy;
         r.z = za + vpa_atan(k);
      end else begin
         r.x = xa - dx;
         r.y = ya + dy;
         r.z = za - vpa_atan(k);
      end
      return r;
   endfunction

   assign rdy[CORDIC_STAGES] = out_ready;
   assign in_ready           = rdy[0];
   assign out_valid          = valid_ff[CORDIC_STAGES-1];
   assign out_lane1          = lane1_ff[CORDIC_STAGES-1];
   assign out_lane2          = lane2_ff[CORDIC_STAGES-1];
   assign out_meta           = meta_ff[CORDIC_STAGES-1];

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      if (i == 0) begin : g_head
         assign valid_src[i] = in_valid;
         assign lane1_src[i] = in_lane1;
         assign lane2_src[i] = in_lane2;
         assign meta_src[i]  = in_meta;
      end else begin : g_link
         assign valid_src[i] = valid_ff[i-1];
         assign lane1_src[i] = lane1_ff[i-1];
         assign lane2_src[i] = lane2_ff[i-1];
         assign meta_src[i]  = meta_ff[i-1];
      end

      assign rdy[i]      = !valid_ff[i] || rdy[i+1];
      assign lane1_in[i] = step(lane1_src[i], i);
      assign lane2_in[i] = step(lane2_src[i], i);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            valid_ff[i] <= valid_src[i];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[i] && valid_src[i]) begin
            lane1_ff[i] <= lane1_in[i];
            lane2_ff[i] <= lane2_in[i];
            meta_ff[i]  <= meta_src[i];
         end
      end
   end

endmodule

`default_nettype wire

/* sv/vpa_fold.sv */
// Clamp and quadrant fold of the CORDIC angle, then rounding to output precision.
`default_nettype none

module vpa_fold (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  vpa_pkg::vpa_lane_type         in_lane1,
   input  vpa_pkg::vpa_lane_type         in_lane2,
   input  vpa_pkg::vpa_meta_type         in_meta,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [vpa_pkg::ANGLE_BITS-1:0] out_angle1,
   output logic [vpa_pkg::ANGLE_BITS-1:0] out_angle2,
   output vpa_pkg::vpa_meta_type         out_meta
);
   import vpa_pkg::*;

   logic                  valid_a_ff, valid_b_ff;
   logic                  rdy_a, rdy_b;
   logic [FW-1:0]         full1_ff, full1_in;
   logic [FW-1:0]         full2_ff, full2_in;
   vpa_meta_type          meta_a_ff, meta_b_ff;
   logic [ANGLE_BITS-1:0] angle1_ff, angle1_in;
   logic [ANGLE_BITS-1:0] angle2_ff, angle2_in;

   function automatic logic [FW-1:0] fold(input logic signed [ZW-1:0] z, input vpa_flags_type f);
      logic signed [ZW-1:0] q;
      logic [FW-1:0]        qu;
      logic [FW-1:0]        r;
      if (f.ay_zero) begin
         q = '0;
      end else if (f.ax_zero) begin
         q = QUARTER_Z;
      end else if (z < 0) begin
         q = '0;
      end else if (z > QUARTER_Z) begin
         q = QUARTER_Z;
      end else begin
         q = z;
      end
      qu = FW'(unsigned'(q));
      case ({f.neg_y, f.neg_x})
         2'b00:   r = qu;
         2'b01:   r = HALF_F - qu;
         2'b11:   r = HALF_F + qu;
         default: r = FULL_F - qu;
      endcase
      return r;
   endfunction

   function automatic logic [ANGLE_BITS-1:0] round_angle(input logic [FW-1:0] full);
      logic [FW-1:0] sum;
      logic [RW-1:0] r;
      sum = full + ROUND_HALF;
      r   = sum[FW-1:RSHIFT];
      if (r >= FULL_A) begin
         r = r - FULL_A;
      end
      return r[ANGLE_BITS-1:0];
   endfunction

   always_comb begin
      full1_in  = fold(in_lane1.z, in_meta.vec1);
      full2_in  = fold(in_lane2.z, in_meta.vec2);
      // zero vector reads as angle 0
      angle1_in = (meta_a_ff.vec1.ax_zero && meta_a_ff.vec1.ay_zero) ? '0 : round_angle(full1_ff);
      angle2_in = (meta_a_ff.vec2.ax_zero && meta_a_ff.vec2.ay_zero) ? '0 : round_angle(full2_ff);
   end

   assign rdy_b      = !valid_b_ff || out_ready;
   assign rdy_a      = !valid_a_ff || rdy_b;
   assign in_ready   = rdy_a;
   assign out_valid  = valid_b_ff;
   assign out_angle1 = angle1_ff;
   assign out_angle2 = angle2_ff;
   assign out_meta   = meta_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            valid_a_ff <= in_valid;
         end
         if (rdy_b) begin
            valid_b_ff <= valid_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         full1_ff  <= full1_in;
         full2_ff  <= full2_in;
         meta_a_ff <= in_meta;
      end
      if (rdy_b && valid_a_ff) begin
         angle1_ff <= angle1_in;
         angle2_ff <= angle2_in;
         meta_b_ff <= meta_a_ff;
      end
   end

endmodule

`default_nettype wire

/* sv/vpa_out.sv */
// Output stage: directed angle, flags and the result register.
`default_nettype none

module vpa_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [vpa_pkg::ANGLE_BITS-1:0] in_angle1,
   input  logic [vpa_pkg::ANGLE_BITS-1:0] in_angle2,
   input  vpa_pkg::vpa_meta_type         in_meta,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output vpa_pkg::vpa_rsp_type          rsp_data
);
   import vpa_pkg::*;

   logic          valid_ff;
   vpa_rsp_type   rsp_ff, rsp_in;
   logic          zero1, zero2;
   logic [RW-1:0] a1, a2, between;

   always_comb begin
      zero1 = in_meta.vec1.ax_zero && in_meta.vec1.ay_zero;
      zero2 = in_meta.vec2.ax_zero && in_meta.vec2.ay_zero;
      a1    = RW'(in_angle1);
      a2    = RW'(in_angle2);
      if (a1 > a2) begin
         between = a1 - a2;
      end else begin
         between = a1 + FULL_A - a2;
      end
      rsp_in.first_angle    = in_angle1;
      rsp_in.second_angle   = in_angle2;
      rsp_in.undefined_flag = zero1 || zero2;
      rsp_in.stop_flag      = zero1 && zero2;
      rsp_in.between_angle  = (zero1 && zero2) ? '0 : between[ANGLE_BITS-1:0];
   end

   assign in_ready  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

/* sv/vector_pair_angle_core.sv */
// Top level of the vector pair angle core: prep, CORDIC, fold and output stages.
// Registers from request to response: prep, the CORDIC stages, the fold and rounding registers, then the result.
// Throughput: one transfer per cycle while rsp_ready stays high; set by the one-iteration-per-stage CORDIC pipeline.
// Each stage holds under backpressure and empty stages still accept, so bubbles close up.
// Reset is synchronous, active high, and clears only the valid bits of every stage.
`default_nettype none

module vector_pair_angle_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  vpa_pkg::vpa_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output vpa_pkg::vpa_rsp_type rsp_data
);
   import vpa_pkg::*;

   logic                  prep_valid, prep_ready;
   vpa_lane_type          prep_lane1, prep_lane2;
   vpa_meta_type          prep_meta;
   logic                  cordic_valid, cordic_ready;
   vpa_lane_type          cordic_lane1, cordic_lane2;
   vpa_meta_type          cordic_meta;
   logic                  fold_valid, fold_ready;
   logic [ANGLE_BITS-1:0] fold_angle1, fold_angle2;
   vpa_meta_type          fold_meta;

   vpa_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_lane1 (prep_lane1),
      .out_lane2 (prep_lane2),
      .out_meta  (prep_meta)
   );

   vpa_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_lane1  (prep_lane1),
      .in_lane2  (prep_lane2),
      .in_meta   (prep_meta),
      .out_valid (cordic_valid),
      .out_ready (cordic_ready),
      .out_lane1 (cordic_lane1),
      .out_lane2 (cordic_lane2),
      .out_meta  (cordic_meta)
   );

   vpa_fold u_fold (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (cordic_valid),
      .in_ready   (cordic_ready),
      .in_lane1   (cordic_lane1),
      .in_lane2   (cordic_lane2),
      .in_meta    (cordic_meta),
      .out_valid  (fold_valid),
      .out_ready  (fold_ready),
      .out_angle1 (fold_angle1),
      .out_angle2 (fold_angle2),
      .out_meta   (fold_meta)
   );

   vpa_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fold_valid),
      .in_ready  (fold_ready),
      .in_angle1 (fold_angle1),
      .in_angle2 (fold_angle2),
      .in_meta   (fold_meta),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* sv/vpa_checker.sv */
// Port-level checks of the vector pair angle core, bound to the top level.
`default_nettype none

module vpa_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire vpa_pkg::vpa_rsp_type rsp_data
);
   import vpa_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stop_flag |->
         rsp_data.undefined_flag && rsp_data.first_angle == '0 &&
         rsp_data.second_angle == '0 && rsp_data.between_angle == '0)
      else $error("stop transfer with nonzero angles");

   a_between_direct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.stop_flag &&
      (rsp_data.first_angle > rsp_data.second_angle) |->
         RW'(rsp_data.between_angle) ==
         RW'(rsp_data.first_angle) - RW'(rsp_data.second_angle))
      else $error("directed angle mismatch");

   a_between_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.stop_flag &&
      (rsp_data.first_angle <= rsp_data.second_angle) |->
         RW'(rsp_data.between_angle) ==
         RW'(rsp_data.first_angle) + FULL_A - RW'(rsp_data.second_angle))
      else $error("wrapped directed angle mismatch");

endmodule

bind vector_pair_angle_core vpa_checker u_vpa_checker (.*);

`default_nettype wire
